@@ hdl/sgpa_pkg.sv @@
// Shared constants, types and codes for the segment pool allocator.
package sgpa_pkg;

	// Pool geometry
	localparam int POOL_SEGMENTS = 16;
	localparam int SEGMENT_BYTES = 256;
	localparam int POOL_BYTES    = POOL_SEGMENTS * SEGMENT_BYTES;
	localparam int IDX_W         = $clog2(POOL_SEGMENTS);
	localparam int SEG_SHIFT     = $clog2(SEGMENT_BYTES);

	// Field widths
	localparam int OP_W    = 2;
	localparam int REQ_W   = 16;
	localparam int OFF_W   = 14;
	localparam int STAT_W  = 3;
	localparam int SIDX_W  = 4;
	localparam int SOFF_W  = 12;
	localparam int CNT_W   = 5;
	localparam int FCNT_W  = $clog2(POOL_SEGMENTS + 1);
	localparam int IN_W    = 32;
	localparam int OUT_W   = 32;

	localparam logic [CNT_W-1:0] CNT_MAX         = '1;
	localparam logic [CNT_W-1:0] RX_CAP_RESET    = CNT_W'(8);

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC_SEND = 2'd0,
		OP_ALLOC_RECV = 2'd1,
		OP_FREE_SEND  = 2'd2,
		OP_FREE_RECV  = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_RECV_CAP  = 3'd2,
		ST_TOO_LARGE = 3'd3,
		ST_OUTSIDE   = 3'd4,
		ST_NOT_ALLOC = 3'd5
	} status_t;

	// Control into the scan unit
	typedef struct packed {
		logic             start;
		logic             probe;  // check one entry for busy instead of seeking free
		logic [IDX_W-1:0] base;
	} scan_ctl_t;

	// Status back from the scan unit
	typedef struct packed {
		logic             done;
		logic             hit;
		logic [IDX_W-1:0] index;
	} scan_stat_t;

endpackage

@@ hdl/sgpa_scan.sv @@
// Iterative bitmap scan unit: one entry compared per cycle.
module sgpa_scan
	import sgpa_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  scan_ctl_t                ctl,
	input  logic [POOL_SEGMENTS-1:0] busy,
	output scan_stat_t               stat
);

	logic             run_q;
	logic             probe_q;
	logic [IDX_W-1:0] idx_q;
	logic             hit;
	logic             last;

	// Shared compare: a probe looks for a busy entry, a seek for a free one
	assign hit  = (busy[idx_q] == probe_q);
	assign last = (idx_q == IDX_W'(POOL_SEGMENTS - 1));

	assign stat.done  = run_q & (hit | probe_q | last);
	assign stat.hit   = hit;
	assign stat.index = idx_q;

	// Sequencer for the walk over the bitmap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			probe_q <= 1'b0;
			idx_q   <= '0;
		end else if (ctl.start) begin
			run_q   <= 1'b1;
			probe_q <= ctl.probe;
			idx_q   <= ctl.base;
		end else if (run_q) begin
			if (stat.done) begin
				run_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

endmodule

@@ hdl/segment_pool_allocator_unit.sv @@
// Segment pool allocator top level: request sequencer, pool state and result register.
//
// Manages a pool of 16 segments of 256 bytes with a busy bitmap. Each
// request (s_tuser selects alloc send, alloc receive, free send, free
// receive) is taken in one transaction and answered by exactly one result
// transaction. An allocation walks the bitmap one entry per cycle from
// entry 0 until the lowest free segment is found or the last entry is
// reached. An allocation refused by the receive cap or the size check, and a
// free outside the pool, skip the scan; any other free probes its one entry
// in the same scan unit. A result still waiting in the output register
// holds off the write of the next one. s_tready is high only while no
// request is in progress; a finished result waits in the output register
// while the next request is accepted. The receive cap register (reset 8)
// may be written through cfg_* whenever no request is in flight.
module segment_pool_allocator_unit
	import sgpa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// Request stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,   // required_bytes[15:0], release_offset[29:16], pad
	input  logic [OP_W-1:0]   s_tuser,   // opcode[1:0]
	// Result stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // status[2:0], segment_index[6:3],
	                                     // segment_offset[18:7], any_free[19],
	                                     // send_used[24:20], receive_used[29:25], pad
	// Receive cap register
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CNT_W-1:0]  cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EVAL = 4'b0010,
		S_SCAN = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t                   state_q;
	op_t                      op_q;
	logic [REQ_W-1:0]         req_q;
	logic signed [OFF_W-1:0]  off_q;
	status_t                  res_status_q;
	logic [IDX_W-1:0]         res_idx_q;

	logic [POOL_SEGMENTS-1:0] busy_q;
	logic [CNT_W-1:0]         send_cnt_q;
	logic [CNT_W-1:0]         recv_cnt_q;
	logic [FCNT_W-1:0]        free_cnt_q;
	logic [CNT_W-1:0]         rx_cap_q;

	logic                     out_valid_q;
	logic [OUT_W-1:0]         out_data_q;

	scan_ctl_t                scan_ctl;
	scan_stat_t               scan_st;

	logic                     in_acc;
	logic                     commit;
	logic                     is_alloc;
	logic                     outside;
	logic [IDX_W-1:0]         free_idx;
	logic                     ok;
	logic [CNT_W-1:0]         send_nxt;
	logic [CNT_W-1:0]         recv_nxt;
	logic [FCNT_W-1:0]        free_nxt;
	logic [SIDX_W-1:0]        out_idx;
	logic [SOFF_W-1:0]        out_off;

	assign s_tready  = (state_q == S_IDLE);
	assign in_acc    = s_tvalid & s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	// Request decode on the held transaction
	assign is_alloc = (op_q == OP_ALLOC_SEND) || (op_q == OP_ALLOC_RECV);
	assign outside  = off_q[OFF_W-1] ||
	                  ({1'b0, off_q[OFF_W-2:0]} >= OFF_W'(POOL_BYTES));
	assign free_idx = IDX_W'(off_q[OFF_W-2:0] >> SEG_SHIFT);

	// Scan unit launch
	always_comb begin
		scan_ctl       = '0;
		scan_ctl.probe = !is_alloc;
		scan_ctl.base  = is_alloc ? '0 : free_idx;
		if (state_q == S_EVAL) begin
			if (is_alloc) begin
				scan_ctl.start = !((op_q == OP_ALLOC_RECV) && (recv_cnt_q >= rx_cap_q)) &&
				                 (req_q <= REQ_W'(SEGMENT_BYTES));
			end else begin
				scan_ctl.start = !outside;
			end
		end
	end

	sgpa_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.busy   (busy_q),
		.stat   (scan_st)
	);

	// Counter updates applied when the result is written
	assign ok     = (res_status_q == ST_OK);
	assign commit = (state_q == S_DONE) && (!out_valid_q || m_tready);

	always_comb begin
		send_nxt = send_cnt_q;
		recv_nxt = recv_cnt_q;
		free_nxt = free_cnt_q;
		if (ok) begin
			case (op_q)
				OP_ALLOC_SEND: begin
					send_nxt = (send_cnt_q == CNT_MAX) ? CNT_MAX : send_cnt_q + CNT_W'(1);
					free_nxt = free_cnt_q - FCNT_W'(1);
				end
				OP_ALLOC_RECV: begin
					recv_nxt = (recv_cnt_q == CNT_MAX) ? CNT_MAX : recv_cnt_q + CNT_W'(1);
					free_nxt = free_cnt_q - FCNT_W'(1);
				end
				OP_FREE_SEND: begin
					send_nxt = (send_cnt_q == '0) ? '0 : send_cnt_q - CNT_W'(1);
					free_nxt = free_cnt_q + FCNT_W'(1);
				end
				OP_FREE_RECV: begin
					recv_nxt = (recv_cnt_q == '0) ? '0 : recv_cnt_q - CNT_W'(1);
					free_nxt = free_cnt_q + FCNT_W'(1);
				end
				default: begin
					free_nxt = free_cnt_q;
				end
			endcase
		end
	end

	assign out_idx = ok ? SIDX_W'(res_idx_q) : '0;
	assign out_off = (ok && is_alloc) ? SOFF_W'({res_idx_q, SEG_SHIFT'(0)}) : '0;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) state_q <= S_EVAL;
				end
				S_EVAL: begin
					state_q <= scan_ctl.start ? S_SCAN : S_DONE;
				end
				S_SCAN: begin
					if (scan_st.done) state_q <= S_DONE;
				end
				S_DONE: begin
					if (commit) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request hold and result status
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= op_t'(s_tuser);
			req_q <= s_tdata[REQ_W-1:0];
			off_q <= s_tdata[REQ_W+OFF_W-1:REQ_W];
		end
		if (state_q == S_EVAL && !scan_ctl.start) begin
			res_idx_q <= '0;
			if (!is_alloc) begin
				res_status_q <= ST_OUTSIDE;
			end else if ((op_q == OP_ALLOC_RECV) && (recv_cnt_q >= rx_cap_q)) begin
				res_status_q <= ST_RECV_CAP;
			end else begin
				res_status_q <= ST_TOO_LARGE;
			end
		end else if (state_q == S_SCAN && scan_st.done) begin
			res_idx_q <= scan_st.index;
			if (scan_st.hit) begin
				res_status_q <= ST_OK;
			end else begin
				res_status_q <= is_alloc ? ST_EMPTY : ST_NOT_ALLOC;
			end
		end
	end

	// Pool state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= '0;
			send_cnt_q <= '0;
			recv_cnt_q <= '0;
			free_cnt_q <= FCNT_W'(POOL_SEGMENTS);
			rx_cap_q   <= RX_CAP_RESET;
		end else begin
			if (cfg_valid && cfg_ready) rx_cap_q <= cfg_data;
			if (commit) begin
				send_cnt_q <= send_nxt;
				recv_cnt_q <= recv_nxt;
				free_cnt_q <= free_nxt;
				if (ok) busy_q[res_idx_q] <= is_alloc;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_data_q <= OUT_W'({recv_nxt, send_nxt, (free_nxt != '0),
			                      out_off, out_idx, res_status_q});
		end
	end

	// Free count tracks the bitmap
	a_none_free: assert property (@(posedge clk) disable iff (!arst_n)
		(free_cnt_q == '0) |-> (&busy_q))
		else $error("free count zero with a free segment");

	a_all_free: assert property (@(posedge clk) disable iff (!arst_n)
		(free_cnt_q == FCNT_W'(POOL_SEGMENTS)) |-> (busy_q == '0))
		else $error("free count full with a busy segment");

	a_scan_owner: assert property (@(posedge clk) disable iff (!arst_n)
		scan_st.done |-> (state_q == S_SCAN))
		else $error("scan finished outside scan state");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && !m_tready) |=> (state_q == S_DONE))
		else $error("result written over a pending transaction");

endmodule
